// ===== src/utf8_strict_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 strict decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_STRICT_DECODER_TOP_DEFINES_SVH
`define UTF8_STRICT_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define U8D_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8d assertion failed");
// next-cycle implication
`define U8D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8d assertion failed");
`else
`define U8D_ASSERT_IMPL(label, ante, cons)
`define U8D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 strict decoder package
// Request and result types, status codes and the lead byte length function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

	localparam int OFFSET_BITS_DEFAULT = 32;
	localparam int START_OFFSET_W      = 32;
	localparam int CP_W                = 21;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVALID  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} req_t;

	typedef struct packed {
		logic [CP_W-1:0]           scalar_value;
		logic [START_OFFSET_W-1:0] start_offset;
		logic [2:0]                scalar_length;
		logic [1:0]                status;
		logic                      last;
	} res_t;

	// total sequence length for a lead byte, 0 when not a valid lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] n;
		case (b) inside
			[8'h00:8'h7F]: n = 3'd1;
			[8'hC2:8'hDF]: n = 3'd2;
			[8'hE0:8'hEF]: n = 3'd3;
			[8'hF0:8'hF4]: n = 3'd4;
			default:       n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== src/utf8_strict_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 strict decoder
// Streaming byte-wise UTF-8 decoder with strict validation and error status.
// ----------------------------------------------------------------------------
// One byte request is taken per cycle unless a result waits with res_ready low.
// Each byte waits in the input register while the decode logic updates the
// sequence state and loads the result register, so a result passes through the
// input register and then the result register after its last byte is taken.
// byte_ready follows res_ready combinationally through the input register; a
// stalled result stalls the stream. Scalars carry their first byte offset and
// length; the first error gives one result with last set and the rest of the
// message is dropped up to end_of_message. Offsets are counted in OFFSET_BITS
// bits; a byte after 2^OFFSET_BITS bytes flags too long.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_strict_decoder_top_defines.svh"

module utf8_strict_decoder_top #(
	parameter int OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_valid,
	output logic               byte_ready,
	input  wire u8d_pkg::req_t byte_req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output u8d_pkg::res_t      res
);

	localparam int CP_W = u8d_pkg::CP_W;

	// input stage
	logic          valid_s1;
	u8d_pkg::req_t req_s1;
	logic          advance;

	// decode state
	logic [CP_W-1:0]        acc_q,       acc_d;
	logic [7:0]             lead_q,      lead_d;
	logic [1:0]             seen_q,      seen_d;
	logic [OFFSET_BITS:0]   offset_q,    offset_d;
	logic [OFFSET_BITS-1:0] seq_start_q, seq_start_d;
	logic                   disc_q,      disc_d;

	// result stage
	logic          res_valid_q;
	u8d_pkg::res_t res_q;
	logic          emit;
	u8d_pkg::res_t res_d;

	// decode intermediates
	logic [7:0]             b;
	logic                   eom;
	logic [2:0]             n_lead;
	logic [2:0]             n_cur;
	logic [2:0]             seen_inc;
	logic [CP_W-1:0]        acc_shift;
	logic                   good;
	logic [OFFSET_BITS-1:0] cur;
	logic [OFFSET_BITS-1:0] ones;
	logic                   fail;
	logic [1:0]             fail_status;
	logic [OFFSET_BITS-1:0] fail_start;

	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign byte_ready = !valid_s1 || advance;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			req_s1 <= byte_req;
		end
	end

	always_comb begin
		b           = req_s1.data_byte;
		eom         = req_s1.end_of_message;
		n_lead      = u8d_pkg::seq_len(lead_q);
		n_cur       = u8d_pkg::seq_len(b);
		seen_inc    = {1'b0, seen_q} + 3'd1;
		acc_shift   = {acc_q[CP_W-7:0], b[5:0]};
		cur         = offset_q[OFFSET_BITS-1:0];
		ones        = '1;
		good        = (b[7:6] == 2'b10);
		fail        = 1'b0;
		fail_status = u8d_pkg::STATUS_INVALID;
		fail_start  = seq_start_q;

		acc_d       = acc_q;
		lead_d      = lead_q;
		seen_d      = seen_q;
		offset_d    = offset_q;
		seq_start_d = seq_start_q;
		disc_d      = disc_q;

		emit               = 1'b0;
		res_d.scalar_value = '0;
		res_d.start_offset = '0;
		res_d.scalar_length = '0;
		res_d.status       = u8d_pkg::STATUS_OK;
		res_d.last         = eom;

		if (seen_q == 2'd1) begin
			if (lead_q == 8'hE0 && b < 8'hA0) good = 1'b0;
			if (lead_q == 8'hED && b > 8'h9F) good = 1'b0;
			if (lead_q == 8'hF0 && b < 8'h90) good = 1'b0;
			if (lead_q == 8'hF4 && b > 8'h8F) good = 1'b0;
		end

		if (disc_q) begin
			// swallow to end of message
		end else if (offset_q[OFFSET_BITS]) begin
			fail        = 1'b1;
			fail_status = u8d_pkg::STATUS_TOO_LONG;
			fail_start  = ones;
		end else begin
			offset_d = offset_q + 1'b1;
			if (seen_q == 2'd0) begin
				if (n_cur == 3'd0) begin
					fail       = 1'b1;
					fail_start = cur;
				end else if (n_cur == 3'd1) begin
					emit                = 1'b1;
					res_d.scalar_value  = CP_W'(b);
					res_d.start_offset  = u8d_pkg::START_OFFSET_W'(cur);
					res_d.scalar_length = 3'd1;
				end else begin
					lead_d      = b;
					seq_start_d = cur;
					seen_d      = 2'd1;
					case (n_cur)
						3'd2:    acc_d = CP_W'(b[4:0]);
						3'd3:    acc_d = CP_W'(b[3:0]);
						default: acc_d = CP_W'(b[2:0]);
					endcase
					if (eom) begin
						fail       = 1'b1;
						fail_start = cur;
					end
				end
			end else begin
				if (!good) begin
					fail = 1'b1;
				end else if (seen_inc >= n_lead) begin
					if (acc_shift > u8d_pkg::MAX_SCALAR) begin
						fail = 1'b1;
					end else begin
						emit                = 1'b1;
						res_d.scalar_value  = acc_shift;
						res_d.start_offset  = u8d_pkg::START_OFFSET_W'(seq_start_q);
						res_d.scalar_length = n_lead;
						seen_d              = 2'd0;
						acc_d               = '0;
					end
				end else begin
					acc_d  = acc_shift;
					seen_d = seen_inc[1:0];
					if (eom) fail = 1'b1;
				end
			end
		end

		if (fail) begin
			emit                = 1'b1;
			res_d.scalar_value  = '0;
			res_d.start_offset  = u8d_pkg::START_OFFSET_W'(fail_start);
			res_d.scalar_length = '0;
			res_d.status        = fail_status;
			res_d.last          = 1'b1;
			disc_d              = 1'b1;
			seen_d              = 2'd0;
			acc_d               = '0;
		end

		if (eom) begin
			acc_d       = '0;
			lead_d      = '0;
			seen_d      = 2'd0;
			offset_d    = '0;
			seq_start_d = '0;
			disc_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			lead_q      <= '0;
			seen_q      <= '0;
			offset_q    <= '0;
			seq_start_q <= '0;
			disc_q      <= 1'b0;
		end else if (advance) begin
			acc_q       <= acc_d;
			lead_q      <= lead_d;
			seen_q      <= seen_d;
			offset_q    <= offset_d;
			seq_start_q <= seq_start_d;
			disc_q      <= disc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	`U8D_ASSERT_IMPL(a_disc_idle, disc_q, seen_q == 2'd0 && acc_q == '0)
	`U8D_ASSERT_IMPL(a_err_fields, res_valid_q && res_q.status != u8d_pkg::STATUS_OK,
		res_q.last && res_q.scalar_length == 3'd0 && res_q.scalar_value == '0)
	`U8D_ASSERT_IMPL(a_ok_fields, res_valid_q && res_q.status == u8d_pkg::STATUS_OK,
		res_q.scalar_length != 3'd0 && res_q.scalar_value <= u8d_pkg::MAX_SCALAR)
	`U8D_ASSERT_NEXT(a_eom_clears, advance && req_s1.end_of_message,
		!disc_q && offset_q == '0 && seen_q == 2'd0)

endmodule

`default_nettype wire

// ===== tb/tb_utf8_strict_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 strict decoder testbench
// Streams byte requests into the decoder and checks every result, field by
// field, against a cycle-free prediction built from the same byte stream.
// Directed cases cover valid extremes, bad leads, bad second and continuation
// bytes and truncated messages; the rest is random messages with noise, part
// of them sent with no stalls at all. Otherwise both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_strict_decoder_top;

	localparam int          OFFSET_BITS  = u8d_pkg::OFFSET_BITS_DEFAULT;
	localparam logic [32:0] OFFSET_LIMIT = 33'd1 << OFFSET_BITS;
	localparam logic [31:0] OFFSET_MASK  = 32'(OFFSET_LIMIT - 33'd1);
	localparam int          CYCLE_LIMIT  = 1_500_000;
	localparam int          RANDOM_BYTES = 600;
	localparam int          BURST_BYTES  = 230;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	u8d_pkg::req_t byte_req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	u8d_pkg::res_t res;

	// decoder state as predicted
	logic [20:0] acc = '0;
	logic [7:0]  lead = '0;
	logic [2:0]  seen = '0;
	logic [32:0] offset_count = '0;
	logic [31:0] seq_start = '0;
	logic        swallowing = 1'b0;

	u8d_pkg::res_t results_due[$];
	u8d_pkg::res_t due;
	logic [7:0]    msg_bytes[$];
	logic          no_idle = 1'b0;
	int            errors = 0;
	int            cycles = 0;
	int            random_bytes = 0;

	utf8_strict_decoder_top #(
		.OFFSET_BITS(OFFSET_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_req  (byte_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ready <= no_idle || ($urandom_range(99) >= 28);
	end

	function automatic logic [2:0] bytes_for_lead(input logic [7:0] b);
		if (b <= 8'h7F)
			return 3'd1;
		else if (b >= 8'hC2 && b <= 8'hDF)
			return 3'd2;
		else if (b >= 8'hE0 && b <= 8'hEF)
			return 3'd3;
		else if (b >= 8'hF0 && b <= 8'hF4)
			return 3'd4;
		return 3'd0;
	endfunction

	function automatic void clear_message();
		acc = '0;
		lead = '0;
		seen = '0;
		offset_count = '0;
		seq_start = '0;
		swallowing = 1'b0;
	endfunction

	function automatic void queue_result(input logic [20:0] cp, input logic [31:0] start,
			input logic [2:0] len, input logic [1:0] st, input logic fin);
		u8d_pkg::res_t r;
		r.scalar_value = cp;
		r.start_offset = start & OFFSET_MASK;
		r.scalar_length = len;
		r.status = st;
		r.last = fin;
		results_due.push_back(r);
	endfunction

	function automatic void flag_error(input logic [31:0] start, input logic [1:0] st,
			input logic eom);
		queue_result('0, start, 3'd0, st, 1'b1);
		if (eom) begin
			clear_message();
		end else begin
			swallowing = 1'b1;
			seen = '0;
			acc = '0;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eom);
		logic [32:0] here;
		logic [2:0]  want;
		logic        ok;
		if (swallowing) begin
			if (eom)
				clear_message();
		end else if (offset_count >= OFFSET_LIMIT) begin
			flag_error(OFFSET_MASK, u8d_pkg::STATUS_TOO_LONG, eom);
		end else begin
			here = offset_count;
			offset_count = offset_count + 33'd1;
			if (seen == 3'd0) begin
				want = bytes_for_lead(b);
				if (want == 3'd0) begin
					flag_error(here[31:0], u8d_pkg::STATUS_INVALID, eom);
				end else if (want == 3'd1) begin
					queue_result(21'(b), here[31:0], 3'd1, u8d_pkg::STATUS_OK, eom);
					if (eom)
						clear_message();
				end else begin
					lead = b;
					acc = (want == 3'd2) ? 21'(b[4:0]) :
						(want == 3'd3) ? 21'(b[3:0]) : 21'(b[2:0]);
					seq_start = here[31:0];
					seen = 3'd1;
					if (eom)
						flag_error(seq_start, u8d_pkg::STATUS_INVALID, eom);
				end
			end else begin
				ok = (b[7:6] == 2'b10);
				if (seen == 3'd1) begin
					if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
					if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
					if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
					if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
				end
				if (!ok) begin
					flag_error(seq_start, u8d_pkg::STATUS_INVALID, eom);
				end else begin
					acc = {acc[14:0], b[5:0]};
					seen = seen + 3'd1;
					want = bytes_for_lead(lead);
					if (seen >= want) begin
						if (acc > u8d_pkg::MAX_SCALAR) begin
							flag_error(seq_start, u8d_pkg::STATUS_INVALID, eom);
						end else begin
							queue_result(acc, seq_start, want, u8d_pkg::STATUS_OK, eom);
							seen = '0;
							acc = '0;
							if (eom)
								clear_message();
						end
					end else if (eom) begin
						flag_error(seq_start, u8d_pkg::STATUS_INVALID, eom);
					end
				end
			end
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result expected none, got cp=%h off=%h len=%0d st=%0d last=%b",
					$time, res.scalar_value, res.start_offset, res.scalar_length, res.status,
					res.last);
				errors++;
			end else begin
				due = results_due.pop_front();
				check_field("scalar_value", 32'(due.scalar_value), 32'(res.scalar_value));
				check_field("start_offset", due.start_offset, res.start_offset);
				check_field("scalar_length", 32'(due.scalar_length), 32'(res.scalar_length));
				check_field("status", 32'(due.status), 32'(res.status));
				check_field("last", 32'(due.last), 32'(res.last));
			end
		end
	end

	// valid is left high after acceptance; the next call replaces the byte or lowers it, and the drain lowers it
	task automatic send_byte(input logic [7:0] b, input logic eom);
		while (!no_idle && $urandom_range(99) < 28) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_req <= '{data_byte: b, end_of_message: eom};
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		decode_byte(b, eom);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		random_bytes += msg_bytes.size();
		msg_bytes.delete();
	endtask

	function automatic void append_scalar(input logic [20:0] cp);
		if (cp < 21'h80) begin
			msg_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			msg_bytes.push_back({3'b110, cp[10:6]});
			msg_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			msg_bytes.push_back({4'b1110, cp[15:12]});
			msg_bytes.push_back({2'b10, cp[11:6]});
			msg_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			msg_bytes.push_back({5'b11110, cp[20:18]});
			msg_bytes.push_back({2'b10, cp[17:12]});
			msg_bytes.push_back({2'b10, cp[11:6]});
			msg_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic logic [20:0] random_scalar(input int min_len);
		logic [20:0] cp;
		case ($urandom_range(3, min_len - 1))
			0: cp = 21'($urandom_range(8'h7F));
			1: cp = 21'($urandom_range(16'h7FF, 16'h80));
			2: begin
				cp = 21'($urandom_range(16'hFFFF, 16'h800));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = cp - 21'h1000;
			end
			default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
		endcase
		return cp;
	endfunction

	task automatic test_ascii();
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_valid_extremes();
		append_scalar(21'h80);
		append_scalar(21'h7FF);
		append_scalar(21'h800);
		append_scalar(21'hD7FF);
		append_scalar(21'hE000);
		append_scalar(21'hFFFF);
		append_scalar(21'h10000);
		append_scalar(21'h10FFFF);
		send_message();
	endtask

	task automatic test_bad_leads();
		logic [7:0] bad[6] = '{8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF5, 8'hFF};
		foreach (bad[i]) begin
			send_byte(8'h41, 1'b0);
			send_byte(bad[i], i == 5);
			if (i != 5) begin
				send_byte(8'h42, 1'b0);
				send_byte(8'hC2, 1'b1);
			end
		end
	endtask

	task automatic test_bad_second_bytes();
		send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h80, 1'b1);
		send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b1);
		send_byte(8'hF0, 1'b0); send_byte(8'h8F, 1'b1);
		send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b1);
		send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b1);
		send_byte(8'hE1, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hC0, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_truncated();
		send_byte(8'hC3, 1'b1);
		send_byte(8'h41, 1'b0); send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b1);
	endtask

	task automatic test_random_messages(input int n_bytes);
		int kind;
		int pos;
		random_bytes = 0;
		while (random_bytes < n_bytes) begin
			repeat ($urandom_range(10, 1)) begin
				kind = $urandom_range(99);
				if (kind < 80) begin
					append_scalar(random_scalar(1));
				end else if (kind < 92) begin
					msg_bytes.push_back(8'($urandom));
				end else begin
					append_scalar(random_scalar(2));
					pos = msg_bytes.size() - 1 - $urandom_range(1, 0);
					msg_bytes[pos] = 8'($urandom);
				end
			end
			if ($urandom_range(9) == 0 && msg_bytes.size() > 1)
				void'(msg_bytes.pop_back());
			send_message();
		end
	endtask

	// random messages with both sides always ready
	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random_messages(BURST_BYTES);
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii();
		test_valid_extremes();
		test_bad_leads();
		test_bad_second_bytes();
		test_truncated();
		test_random_messages(RANDOM_BYTES);
		test_back_to_back();
		byte_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
